### rtl/dsort_pkg.sv
`default_nettype none

package dsort_pkg;

  localparam int MAX_OBJECTS_DEF = 64;

  localparam int ID_W        = 16;
  localparam int COORD_W     = 24;
  localparam int DIST_W      = 50;
  localparam int SQ_W        = 2 * COORD_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_AW      = 4;
  localparam int APB_DW      = 32;

  localparam logic [1:0] REG_EYE_X = 2'd0;
  localparam logic [1:0] REG_EYE_Y = 2'd1;
  localparam logic [1:0] REG_EYE_Z = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } eye_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dist_sq;
    logic              last;
  } qitem_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dist_sq;
  } entry_t;

endpackage

`default_nettype wire

### rtl/distance_sort_far_to_near_core.sv
// Channel  Dir  Handshake                 Payload
// in_*     in   in_valid / in_ready       object_id, pos_x, pos_y, pos_z, list_end
// out_*    out  out_valid / out_ready     sorted_id, dist_sq, run_last, overflowed
// apb      in   psel, penable / pready    eye_x @0x0, eye_y @0x4, eye_z @0x8
//
// An accepted item passes registers s1, s2 and the queue; the back stores items while in ST_LOAD.
// The list end sorts the n stored entries, skipped for n = 1, over one read and one write port.
// An EMIT_RD read starts the run; each result then waits in EMIT_HOLD until out_ready takes it.
// Reset is synchronous and clears control state and the eye only; the store needs no clearing pass.
// A 4-entry queue lets the front keep accepting items while the back sorts or out_ready stalls.
`default_nettype none

module distance_sort_far_to_near_core #(
  parameter int MAX_OBJECTS = dsort_pkg::MAX_OBJECTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [dsort_pkg::APB_AW-1:0]          paddr,
  input  logic [dsort_pkg::APB_DW-1:0]          pwdata,
  output logic [dsort_pkg::APB_DW-1:0]          prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dsort_pkg::ID_W-1:0]            in_object_id,
  input  logic signed [dsort_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [dsort_pkg::COORD_W-1:0]  in_pos_y,
  input  logic signed [dsort_pkg::COORD_W-1:0]  in_pos_z,
  input  logic                                  in_list_end,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dsort_pkg::ID_W-1:0]            out_sorted_id,
  output logic [dsort_pkg::DIST_W-1:0]          out_dist_sq,
  output logic                                  out_run_last,
  output logic                                  out_overflowed
);

  localparam int CRW = dsort_pkg::COORD_W;
  localparam int EXT = dsort_pkg::APB_DW - dsort_pkg::COORD_W;

  dsort_pkg::eye_t                  eye_r, eye_nxt;
  logic                             cfg_wr;
  logic [1:0]                       cfg_idx;
  logic                             push_valid;
  dsort_pkg::qitem_t                push_item;
  logic [dsort_pkg::QCNT_W-1:0]     q_count;
  logic                             pop_valid;
  logic                             pop_ready;
  dsort_pkg::qitem_t                pop_item;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    eye_nxt = eye_r;
    if (cfg_wr) begin
      case (cfg_idx)
        dsort_pkg::REG_EYE_X: eye_nxt.x = pwdata[CRW-1:0];
        dsort_pkg::REG_EYE_Y: eye_nxt.y = pwdata[CRW-1:0];
        dsort_pkg::REG_EYE_Z: eye_nxt.z = pwdata[CRW-1:0];
        default: eye_nxt = eye_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      dsort_pkg::REG_EYE_X: prdata = {{EXT{eye_r.x[CRW-1]}}, eye_r.x};
      dsort_pkg::REG_EYE_Y: prdata = {{EXT{eye_r.y[CRW-1]}}, eye_r.y};
      dsort_pkg::REG_EYE_Z: prdata = {{EXT{eye_r.z[CRW-1]}}, eye_r.z};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_r <= '0;
    end else begin
      eye_r <= eye_nxt;
    end
  end

  dsort_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .eye          (eye_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_object_id (in_object_id),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .in_list_end  (in_list_end),
    .q_count      (q_count),
    .push_valid   (push_valid),
    .push_item    (push_item)
  );

  dsort_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .q_count    (q_count),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  dsort_back #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sorted_id  (out_sorted_id),
    .out_dist_sq    (out_dist_sq),
    .out_run_last   (out_run_last),
    .out_overflowed (out_overflowed)
  );

endmodule

`default_nettype wire

### rtl/dsort_front.sv
`default_nettype none

module dsort_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dsort_pkg::eye_t                       eye,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dsort_pkg::ID_W-1:0]            in_object_id,
  input  logic signed [dsort_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [dsort_pkg::COORD_W-1:0]  in_pos_y,
  input  logic signed [dsort_pkg::COORD_W-1:0]  in_pos_z,
  input  logic                                  in_list_end,
  input  logic [dsort_pkg::QCNT_W-1:0]          q_count,
  output logic                                  push_valid,
  output dsort_pkg::qitem_t                     push_item
);

  localparam int CW    = dsort_pkg::COORD_W;
  localparam int OCC_W = dsort_pkg::QCNT_W + 1;

  logic                          s1_v_r;
  logic                          s2_v_r;
  logic [dsort_pkg::ID_W-1:0]    s1_id_r;
  logic [dsort_pkg::ID_W-1:0]    s2_id_r;
  logic                          s1_last_r;
  logic                          s2_last_r;
  logic [CW-1:0]                 s1_mx_r;
  logic [CW-1:0]                 s1_my_r;
  logic [CW-1:0]                 s1_mz_r;
  logic [dsort_pkg::SQ_W-1:0]    s2_sx_r;
  logic [dsort_pkg::SQ_W-1:0]    s2_sy_r;
  logic [dsort_pkg::SQ_W-1:0]    s2_sz_r;

  logic signed [CW:0]            dx;
  logic signed [CW:0]            dy;
  logic signed [CW:0]            dz;
  logic [CW:0]                   ax;
  logic [CW:0]                   ay;
  logic [CW:0]                   az;
  logic [OCC_W-1:0]              occ;
  logic                          accept;

  // count every item already committed to the queue, so none is ever refused downstream
  assign occ      = {1'b0, q_count} + OCC_W'(s1_v_r) + OCC_W'(s2_v_r);
  assign in_ready = occ < OCC_W'(dsort_pkg::QUEUE_DEPTH);
  assign accept   = in_valid & in_ready;

  assign dx = $signed({in_pos_x[CW-1], in_pos_x}) - $signed({eye.x[CW-1], eye.x});
  assign dy = $signed({in_pos_y[CW-1], in_pos_y}) - $signed({eye.y[CW-1], eye.y});
  assign dz = $signed({in_pos_z[CW-1], in_pos_z}) - $signed({eye.z[CW-1], eye.z});

  assign ax = dx[CW] ? (~dx + 1'b1) : dx;
  assign ay = dy[CW] ? (~dy + 1'b1) : dy;
  assign az = dz[CW] ? (~dz + 1'b1) : dz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_id_r   <= in_object_id;
    s1_last_r <= in_list_end;
    s1_mx_r   <= ax[CW-1:0];
    s1_my_r   <= ay[CW-1:0];
    s1_mz_r   <= az[CW-1:0];
    s2_id_r   <= s1_id_r;
    s2_last_r <= s1_last_r;
    s2_sx_r   <= dsort_pkg::SQ_W'(s1_mx_r) * dsort_pkg::SQ_W'(s1_mx_r);
    s2_sy_r   <= dsort_pkg::SQ_W'(s1_my_r) * dsort_pkg::SQ_W'(s1_my_r);
    s2_sz_r   <= dsort_pkg::SQ_W'(s1_mz_r) * dsort_pkg::SQ_W'(s1_mz_r);
  end

  assign push_valid        = s2_v_r;
  assign push_item.id      = s2_id_r;
  assign push_item.last    = s2_last_r;
  assign push_item.dist_sq = dsort_pkg::DIST_W'(s2_sx_r) + dsort_pkg::DIST_W'(s2_sy_r)
                           + dsort_pkg::DIST_W'(s2_sz_r);

endmodule

`default_nettype wire

### rtl/dsort_queue.sv
`default_nettype none

module dsort_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_valid,
  input  dsort_pkg::qitem_t             push_item,
  output logic [dsort_pkg::QCNT_W-1:0]  q_count,
  output logic                          pop_valid,
  input  logic                          pop_ready,
  output dsort_pkg::qitem_t             pop_item
);

  dsort_pkg::qitem_t               slot_r [dsort_pkg::QUEUE_DEPTH];
  logic [dsort_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [dsort_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [dsort_pkg::QCNT_W-1:0]    count_r;
  logic                            do_push;
  logic                            do_pop;

  assign do_push   = push_valid && (count_r < dsort_pkg::QCNT_W'(dsort_pkg::QUEUE_DEPTH));
  assign do_pop    = pop_valid && pop_ready;
  assign pop_valid = count_r != '0;
  assign pop_item  = slot_r[rd_ptr_r];
  assign q_count   = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

### rtl/dsort_back.sv
`default_nettype none

module dsort_back #(
  parameter int MAX_OBJECTS = dsort_pkg::MAX_OBJECTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  dsort_pkg::qitem_t               pop_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dsort_pkg::ID_W-1:0]      out_sorted_id,
  output logic [dsort_pkg::DIST_W-1:0]    out_dist_sq,
  output logic                            out_run_last,
  output logic                            out_overflowed
);

  localparam int IW = $clog2(MAX_OBJECTS);
  localparam int CW = $clog2(MAX_OBJECTS + 1);

  localparam logic [2:0] ST_LOAD      = 3'd0;
  localparam logic [2:0] ST_SORT_LD   = 3'd1;
  localparam logic [2:0] ST_SORT_CUR  = 3'd2;
  localparam logic [2:0] ST_SORT_CMP  = 3'd3;
  localparam logic [2:0] ST_SORT_WB   = 3'd4;
  localparam logic [2:0] ST_EMIT_RD   = 3'd5;
  localparam logic [2:0] ST_EMIT_LD   = 3'd6;
  localparam logic [2:0] ST_EMIT_HOLD = 3'd7;

  dsort_pkg::entry_t mem [MAX_OBJECTS];
  dsort_pkg::entry_t rdata_r;

  logic [2:0]                    state_r, state_nxt;
  logic [CW-1:0]                 fill_r, fill_nxt;
  logic                          ovf_r, ovf_nxt;
  logic [IW-1:0]                 i_r, i_nxt;
  logic [IW-1:0]                 j_r, j_nxt;
  logic [IW-1:0]                 k_r, k_nxt;
  dsort_pkg::entry_t             cur_r, cur_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [dsort_pkg::ID_W-1:0]    out_id_r, out_id_nxt;
  logic [dsort_pkg::DIST_W-1:0]  out_dist_r, out_dist_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_ovf_r, out_ovf_nxt;

  logic                          we;
  logic [IW-1:0]                 waddr;
  dsort_pkg::entry_t             wdata;
  logic [IW-1:0]                 raddr;
  logic [CW-1:0]                 fill_inc;
  logic [CW-1:0]                 last_idx;

  assign last_idx = fill_r - 1'b1;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    out_id_nxt    = out_id_r;
    out_dist_nxt  = out_dist_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = cur_r;
    raddr         = '0;
    pop_ready     = 1'b0;
    fill_inc      = fill_r;
    case (state_r)
      ST_LOAD: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (fill_r < CW'(MAX_OBJECTS)) begin
            we            = 1'b1;
            waddr         = fill_r[IW-1:0];
            wdata.id      = pop_item.id;
            wdata.dist_sq = pop_item.dist_sq;
            fill_inc      = fill_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          fill_nxt = fill_inc;
          if (pop_item.last) begin
            i_nxt     = '0;
            k_nxt     = '0;
            state_nxt = (fill_inc > CW'(1)) ? ST_SORT_LD : ST_EMIT_RD;
          end
        end
      end
      ST_SORT_LD: begin
        raddr     = i_r;
        state_nxt = ST_SORT_CUR;
      end
      ST_SORT_CUR: begin
        cur_nxt   = rdata_r;
        j_nxt     = i_r + 1'b1;
        raddr     = i_r + 1'b1;
        state_nxt = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        // swap: the entry in hand drops into slot j, the farther entry stays in hand
        if (rdata_r.dist_sq > cur_r.dist_sq) begin
          we      = 1'b1;
          waddr   = j_r;
          wdata   = cur_r;
          cur_nxt = rdata_r;
        end
        if (CW'(j_r) == last_idx) begin
          state_nxt = ST_SORT_WB;
        end else begin
          j_nxt = j_r + 1'b1;
          raddr = j_r + 1'b1;
        end
      end
      ST_SORT_WB: begin
        we    = 1'b1;
        waddr = i_r;
        wdata = cur_r;
        i_nxt = i_r + 1'b1;
        if (CW'(i_r) + CW'(2) == fill_r) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          state_nxt = ST_SORT_LD;
        end
      end
      ST_EMIT_RD: begin
        raddr     = k_r;
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_id_nxt    = rdata_r.id;
        out_dist_nxt  = rdata_r.dist_sq;
        out_last_nxt  = CW'(k_r) == last_idx;
        out_ovf_nxt   = ovf_r;
        state_nxt     = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            raddr     = k_r + 1'b1;
            state_nxt = ST_EMIT_LD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_id_r   <= out_id_nxt;
    out_dist_r <= out_dist_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_sorted_id  = out_id_r;
  assign out_dist_sq    = out_dist_r;
  assign out_run_last   = out_last_r;
  assign out_overflowed = out_ovf_r;

endmodule

`default_nettype wire

### rtl/dsort_checker.sv
`default_nettype none

module dsort_checker #(
  parameter int MAX_OBJECTS = dsort_pkg::MAX_OBJECTS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dsort_pkg::ID_W-1:0]    out_sorted_id,
  input logic [dsort_pkg::DIST_W-1:0]  out_dist_sq,
  input logic                          out_run_last,
  input logic                          out_overflowed
);

  localparam int CW = $clog2(MAX_OBJECTS + 1);

  logic                          acc;
  logic                          in_run_r;
  logic [CW-1:0]                 run_cnt_r;
  logic [dsort_pkg::DIST_W-1:0]  prev_dist_r;
  logic                          prev_ovf_r;

  assign acc = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r  <= 1'b0;
      run_cnt_r <= '0;
    end else if (acc) begin
      in_run_r  <= !out_run_last;
      run_cnt_r <= out_run_last ? '0 : run_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      prev_dist_r <= out_dist_sq;
      prev_ovf_r  <= out_overflowed;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sorted_id)
      && $stable(out_dist_sq) && $stable(out_run_last))
    else $error("result changed while stalled");

  a_far_to_near: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_run_r |-> out_dist_sq <= prev_dist_r)
    else $error("distance rose within a run");

  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_run_r |-> out_overflowed == prev_ovf_r)
    else $error("overflow flag changed within a run");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (run_cnt_r == CW'(MAX_OBJECTS - 1)) |-> out_run_last)
    else $error("run longer than the store");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind distance_sort_far_to_near_core dsort_checker #(
  .MAX_OBJECTS (MAX_OBJECTS)
) u_dsort_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sorted_id  (out_sorted_id),
  .out_dist_sq    (out_dist_sq),
  .out_run_last   (out_run_last),
  .out_overflowed (out_overflowed)
);

`default_nettype wire

### bench/distance_sort_far_to_near_core_tb.sv
`timescale 1ns / 100ps

module distance_sort_far_to_near_core_tb;

  localparam int ID_W    = dsort_pkg::ID_W;
  localparam int COORD_W = dsort_pkg::COORD_W;
  localparam int DIST_W  = dsort_pkg::DIST_W;
  localparam int APB_AW  = dsort_pkg::APB_AW;
  localparam int APB_DW  = dsort_pkg::APB_DW;

  localparam int MAX_OBJ = dsort_pkg::MAX_OBJECTS_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 500000;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  localparam logic [APB_AW-1:0] ADDR_EYE_X = {dsort_pkg::REG_EYE_X, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_EYE_Y = {dsort_pkg::REG_EYE_Y, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_EYE_Z = {dsort_pkg::REG_EYE_Z, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNUSED = 4'hC;

  typedef enum logic [1:0] {ROW_OBJ, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CM_WIDE, CM_NEAR, CM_REPEAT, CM_EDGE} coord_mode_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      end_flag;
    logic                      typed_check;
    logic [DIST_W-1:0]         dist_sq;
    logic [APB_AW-1:0]         addr;
    logic [APB_DW-1:0]         data;
  } stim_row_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dist_sq;
    logic              last;
    logic              ovf;
  } sorted_obj_t;

  logic                      clk;
  logic                      rst_n;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_AW-1:0]         paddr;
  logic [APB_DW-1:0]         pwdata;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;
  logic                      in_valid;
  logic                      in_ready;
  logic [ID_W-1:0]           in_object_id;
  logic signed [COORD_W-1:0] in_pos_x;
  logic signed [COORD_W-1:0] in_pos_y;
  logic signed [COORD_W-1:0] in_pos_z;
  logic                      in_list_end;
  logic                      out_valid;
  logic                      out_ready;
  logic [ID_W-1:0]           out_sorted_id;
  logic [DIST_W-1:0]         out_dist_sq;
  logic                      out_run_last;
  logic                      out_overflowed;

  dsort_pkg::eye_t   eye_now;
  dsort_pkg::entry_t list_store [MAX_OBJ];
  int                list_fill;
  logic              list_dropped;
  sorted_obj_t       pending_sorted [$];
  stim_row_t         directed [$];
  int                mismatches;
  int                objects_sent;
  int                cycle_count = 0;
  int                send_idle_pct;
  int                recv_idle_pct;

  distance_sort_far_to_near_core #(
    .MAX_OBJECTS(MAX_OBJ)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_object_id(in_object_id),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z),
    .in_list_end(in_list_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sorted_id(out_sorted_id),
    .out_dist_sq(out_dist_sq),
    .out_run_last(out_run_last),
    .out_overflowed(out_overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic [COORD_W:0] diff;
    logic [COORD_W:0] neg;
    diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    neg = -diff;
    return diff[COORD_W] ? neg[COORD_W-1:0] : diff[COORD_W-1:0];
  endfunction

  // Store one object, or flag a drop when the list is full; on the list end, sort far to near and queue the run.
  function automatic void load_object(input logic [ID_W-1:0] id,
                                      input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y,
                                      input logic signed [COORD_W-1:0] z,
                                      input logic end_flag);
    logic [DIST_W-1:0] ax;
    logic [DIST_W-1:0] ay;
    logic [DIST_W-1:0] az;
    dsort_pkg::entry_t tmp;
    sorted_obj_t       r;
    int                i;
    int                j;
    if (list_fill < MAX_OBJ) begin
      ax = DIST_W'(abs_diff(x, eye_now.x));
      ay = DIST_W'(abs_diff(y, eye_now.y));
      az = DIST_W'(abs_diff(z, eye_now.z));
      list_store[list_fill].id = id;
      list_store[list_fill].dist_sq = ax * ax + ay * ay + az * az;
      list_fill++;
    end else begin
      list_dropped = 1'b1;
    end
    if (end_flag) begin
      for (i = 0; i + 1 < list_fill; i++) begin
        for (j = i + 1; j < list_fill; j++) begin
          if (list_store[j].dist_sq > list_store[i].dist_sq) begin
            tmp = list_store[j];
            list_store[j] = list_store[i];
            list_store[i] = tmp;
          end
        end
      end
      for (i = 0; i < list_fill; i++) begin
        r.id = list_store[i].id;
        r.dist_sq = list_store[i].dist_sq;
        r.last = (i == list_fill - 1);
        r.ovf = list_dropped;
        pending_sorted.push_back(r);
      end
      list_fill = 0;
      list_dropped = 1'b0;
    end
  endfunction

  function automatic stim_row_t obj_row(input logic [ID_W-1:0] id,
                                        input logic signed [COORD_W-1:0] x,
                                        input logic signed [COORD_W-1:0] y,
                                        input logic signed [COORD_W-1:0] z,
                                        input logic end_flag,
                                        input logic typed_check,
                                        input logic [DIST_W-1:0] dist_sq);
    stim_row_t r;
    r = '0;
    r.kind = ROW_OBJ;
    r.id = id;
    r.x = x;
    r.y = y;
    r.z = z;
    r.end_flag = end_flag;
    r.typed_check = typed_check;
    r.dist_sq = dist_sq;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [APB_AW-1:0] addr,
                                        input logic [APB_DW-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.addr = addr;
    r.data = data;
    return r;
  endfunction

  function automatic logic [APB_DW-1:0] sext_coord(input logic [COORD_W-1:0] v);
    return {{(APB_DW - COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord(input coord_mode_t mode);
    logic [COORD_W-1:0] v;
    case (mode)
      CM_NEAR: begin
        v = COORD_W'($urandom_range(128, 0));
        v = v - 24'd64;
      end
      CM_EDGE: begin
        case ($urandom_range(3, 0))
          0: v = COORD_MAX;
          1: v = COORD_MIN;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = COORD_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_obj(input logic [ID_W-1:0] id,
                          input logic signed [COORD_W-1:0] x,
                          input logic signed [COORD_W-1:0] y,
                          input logic signed [COORD_W-1:0] z,
                          input logic end_flag,
                          input logic typed_check,
                          input logic [DIST_W-1:0] dist_sq);
    sorted_obj_t r;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_object_id <= id;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_list_end <= end_flag;
    do @(posedge clk); while (!in_ready);
    objects_sent++;
    load_object(id, x, y, z, end_flag);
    if (typed_check) begin
      void'(pending_sorted.pop_back());
      r.id = id;
      r.dist_sq = dist_sq;
      r.last = 1'b1;
      r.ovf = 1'b0;
      pending_sorted.push_back(r);
    end
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a register, then read it back where it is mapped.
  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    logic mapped;
    mapped = 1'b1;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      ADDR_EYE_X: eye_now.x = data[COORD_W-1:0];
      ADDR_EYE_Y: eye_now.y = data[COORD_W-1:0];
      ADDR_EYE_Z: eye_now.z = data[COORD_W-1:0];
      default: mapped = 1'b0;
    endcase
    if (mapped) begin
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata[COORD_W-1:0] !== data[COORD_W-1:0]) begin
        $display("%0t readback mismatch at %h: expected %h, got %h",
                 $time, addr, data[COORD_W-1:0], prdata[COORD_W-1:0]);
        mismatches++;
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_eye(input logic [COORD_W-1:0] x,
                         input logic [COORD_W-1:0] y,
                         input logic [COORD_W-1:0] z);
    write_reg(ADDR_EYE_X, sext_coord(x));
    write_reg(ADDR_EYE_Y, sext_coord(y));
    write_reg(ADDR_EYE_Z, sext_coord(z));
  endtask

  task automatic send_random_list(input int n);
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    coord_mode_t               mode;
    int                        r;
    int                        k;
    px = '0;
    py = '0;
    pz = '0;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99, 0);
      if (r < 45) begin
        mode = CM_WIDE;
      end else if (r < 75) begin
        mode = CM_NEAR;
      end else if (r < 90) begin
        mode = CM_REPEAT;
      end else begin
        mode = CM_EDGE;
      end
      if (mode != CM_REPEAT) begin
        px = rand_coord(mode);
        py = rand_coord(mode);
        pz = rand_coord(mode);
      end
      send_obj(ID_W'($urandom), px, py, pz, k == n - 1, 1'b0, '0);
    end
  endtask

  task automatic run_small_lists(input int target);
    while (objects_sent < target) begin
      send_random_list(($urandom_range(99, 0) < 85) ? $urandom_range(8, 1)
                                                    : $urandom_range(24, 9));
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    sorted_obj_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_sorted.size() == 0) begin
        $display("%0t unexpected transaction: id=%h dist_sq=%h last=%b ovf=%b",
                 $time, out_sorted_id, out_dist_sq, out_run_last, out_overflowed);
        mismatches++;
      end else begin
        want = pending_sorted.pop_front();
        if ({out_sorted_id, out_dist_sq, out_run_last, out_overflowed} !== want) begin
          $display("%0t mismatch: expected %h %h %b %b, got %h %h %b %b",
                   $time, want.id, want.dist_sq, want.last, want.ovf,
                   out_sorted_id, out_dist_sq, out_run_last, out_overflowed);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    in_object_id <= '0;
    in_pos_x <= '0;
    in_pos_y <= '0;
    in_pos_z <= '0;
    in_list_end <= 1'b0;
    mismatches = 0;
    objects_sent = 0;
    eye_now = '0;
    list_fill = 0;
    list_dropped = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 75;

    directed.push_back(obj_row(16'h0000, 24'sd16, 24'sd0, 24'sd0, 1'b1, 1'b1, 50'd256));
    directed.push_back(obj_row(16'hFFFF, -24'sd16, -24'sd16, -24'sd16, 1'b1, 1'b1, 50'd768));
    directed.push_back(obj_row(16'h1234, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1,
                               50'd211106182201347));
    directed.push_back(obj_row(16'h4321, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1,
                               50'd211106232532992));
    directed.push_back(cfg_row(ADDR_EYE_X, sext_coord(COORD_MIN)));
    directed.push_back(cfg_row(ADDR_EYE_Y, sext_coord(COORD_MIN)));
    directed.push_back(cfg_row(ADDR_EYE_Z, sext_coord(COORD_MIN)));
    directed.push_back(obj_row(16'hA5A5, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1,
                               50'd844424829468675));
    directed.push_back(obj_row(16'h5A5A, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1, 50'd0));
    directed.push_back(cfg_row(ADDR_UNUSED, 32'h0000_1234));
    directed.push_back(obj_row(16'h0F0F, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1, 50'd0));
    directed.push_back(cfg_row(ADDR_EYE_X, '0));
    directed.push_back(cfg_row(ADDR_EYE_Y, '0));
    directed.push_back(cfg_row(ADDR_EYE_Z, '0));
    directed.push_back(obj_row(16'd1, 24'sd16, 24'sd0, 24'sd0, 1'b0, 1'b0, '0));
    directed.push_back(obj_row(16'd2, 24'sd0, 24'sd16, 24'sd0, 1'b0, 1'b0, '0));
    directed.push_back(obj_row(16'd3, 24'sd0, 24'sd0, 24'sd16, 1'b0, 1'b0, '0));
    directed.push_back(obj_row(16'd4, 24'sd0, -24'sd16, 24'sd0, 1'b1, 1'b0, '0));
    directed.push_back(obj_row(16'd10, 24'sd32, 24'sd0, 24'sd0, 1'b0, 1'b0, '0));
    directed.push_back(obj_row(16'd11, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b0, '0));
    directed.push_back(obj_row(16'd12, 24'sd16, 24'sd16, 24'sd16, 1'b0, 1'b0, '0));
    directed.push_back(obj_row(16'd13, -24'sd48, 24'sd0, 24'sd0, 1'b0, 1'b0, '0));
    directed.push_back(obj_row(16'd14, 24'sd0, 24'sd32, 24'sd0, 1'b1, 1'b0, '0));
    directed.push_back(obj_row(16'd20, 24'sd16, 24'sd0, 24'sd0, 1'b0, 1'b0, '0));
    directed.push_back(obj_row(16'd21, 24'sd0, 24'sd0, -24'sd64, 1'b0, 1'b0, '0));
    directed.push_back(cfg_row(ADDR_EYE_X, 32'd32));
    directed.push_back(obj_row(16'd22, 24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0, '0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == ROW_CFG) begin
        wait_results_done();
        write_reg(row.addr, row.data);
      end else begin
        send_obj(row.id, row.x, row.y, row.z, row.end_flag, row.typed_check, row.dist_sq);
      end
    end
    wait_results_done();

    set_eye(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    send_random_list(MAX_OBJ);
    wait_results_done();
    run_small_lists(122);
    wait_results_done();

    send_idle_pct = 75;
    recv_idle_pct = 31;
    set_eye(COORD_MAX, COORD_MAX, COORD_MAX);
    send_random_list(MAX_OBJ + 2);
    run_small_lists(225);
    wait_results_done();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_eye(rand_coord(CM_NEAR), rand_coord(CM_NEAR), rand_coord(CM_NEAR));
    run_small_lists(305);
    wait_results_done();

    if (mismatches == 0 && pending_sorted.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
